/* hdl/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared constants, codes and types of the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int TBL_N         = 64;
    localparam int TBL_AW        = $clog2(TBL_N);
    localparam int CNT_W         = TBL_AW + 1;
    localparam int MAX_LAYERS    = 4096;
    localparam int GROWTH_FACTOR = 4;
    localparam int LEN_W         = 13;
    localparam int CAP_W         = LEN_W + $clog2(GROWTH_FACTOR);
    localparam int ENT_W         = 2 * LEN_W;
    localparam int WID_W         = 15;
    localparam int REQW_W        = 16;
    localparam int ORG_W         = 16;
    localparam int FST_W         = 12;
    localparam int STAT_W        = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int IN_DATA_W     = 80;
    localparam int OUT_DATA_W    = 32;

    localparam logic [LEN_W-1:0] RESET_LAYERS = LEN_W'(16);
    localparam logic [WID_W-1:0] RESET_WIDTH  = WID_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_LAYER_WIDTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LAYERS = CFG_IDX_W'(1);

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_WIDTH    = 3'd1;
    localparam logic [STAT_W-1:0] ST_SPACE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTALLOC = 3'd3;
    localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_FREE,
        S_SCAN_ALLOC,
        S_SCAN_NBR,
        S_COMMIT,
        S_DONE
    } ffra_state_t;

    // one memory's access port for a cycle
    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] waddr;
        logic [ENT_W-1:0]  wdata;
        logic [TBL_AW-1:0] raddr;
    } ffra_mem_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FST_W-1:0]  start_layer;
        logic              grew;
        logic [LEN_W-1:0]  capacity;
    } ffra_result_t;

endpackage

/* hdl/ffra_ram.sv */
// ----------------------------------------------------------------------------
// ffra_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/ffra_engine.sv */
// ----------------------------------------------------------------------------
// ffra_engine
// Sequencer that scans the range tables and commits allocate and free updates.
// ----------------------------------------------------------------------------
module ffra_engine
    import ffra_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request side
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                req_func,
    input  logic [REQW_W-1:0]   req_width,
    input  logic [LEN_W-1:0]    req_count,
    input  logic [ORG_W-1:0]    req_ox,
    input  logic [ORG_W-1:0]    req_oy,
    input  logic [FST_W-1:0]    req_where,
    input  logic [WID_W-1:0]    layer_width,
    // reinitialise to one free range of init_cap
    input  logic                init_we,
    input  logic [LEN_W-1:0]    init_cap,
    // memories
    output ffra_mem_req_t       free_req,
    input  logic [ENT_W-1:0]    free_rdata,
    output ffra_mem_req_t       alloc_req,
    input  logic [ENT_W-1:0]    alloc_rdata,
    // result side
    output logic                res_valid,
    input  logic                res_ready,
    output ffra_result_t        res
);

    ffra_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic              init_pend_reg;
    logic [LEN_W-1:0]  total_reg;
    logic [TBL_N-1:0]  free_valid_reg;
    logic [TBL_N-1:0]  alloc_valid_reg;

    logic              func_reg;
    logic [LEN_W-1:0]  count_reg;
    logic [FST_W-1:0]  where_reg;

    logic              best_found_reg;
    logic [TBL_AW-1:0] best_idx_reg;
    logic [LEN_W-1:0]  best_start_reg, best_len_reg;
    logic              aslot_found_reg, fslot_found_reg;
    logic [TBL_AW-1:0] aslot_reg, fslot_reg;
    logic              match_found_reg;
    logic [TBL_AW-1:0] match_idx_reg;
    logic [LEN_W-1:0]  m_start_reg, m_len_reg;
    logic              left_found_reg, right_found_reg;
    logic [TBL_AW-1:0] left_idx_reg, right_idx_reg;
    logic [LEN_W-1:0]  left_start_reg, left_len_reg, right_len_reg;

    logic [STAT_W-1:0] res_status_reg;
    logic [FST_W-1:0]  res_start_reg;
    logic              res_grew_reg;

    logic              accept;
    logic              quick;
    logic [STAT_W-1:0] quick_status;
    logic              scan_last;
    logic              scan_data;
    logic [TBL_AW-1:0] p_idx;
    logic [LEN_W-1:0]  f_start, f_len, a_start, a_len;
    logic              f_vld;

    // commit results
    logic [STAT_W-1:0] c_status;
    logic [FST_W-1:0]  c_start;
    logic              c_grew;
    logic [LEN_W-1:0]  c_total;
    logic              c_fwe;
    logic [TBL_AW-1:0] c_faddr;
    logic [ENT_W-1:0]  c_fdata;
    logic              c_awe;
    logic              c_fset, c_fclr;
    logic [TBL_AW-1:0] c_fset_idx, c_fclr_idx;
    logic              c_aclr;
    logic [CAP_W-1:0]  grown;
    logic [CAP_W-1:0]  region;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE) && !init_pend_reg;
    assign scan_last = (cnt_reg == CNT_W'(TBL_N));
    assign scan_data = (cnt_reg != '0);
    assign p_idx     = TBL_AW'(cnt_reg - CNT_W'(1));
    assign {f_start, f_len} = free_rdata;
    assign {a_start, a_len} = alloc_rdata;
    assign f_vld     = free_valid_reg[p_idx];

    always_comb
    begin
        if (req_func)
        begin
            quick        = (req_ox != '0) || (req_oy != '0);
            quick_status = ST_IGNORED;
        end
        else
        begin
            quick        = (req_width != {1'b0, layer_width}) || (req_count == '0);
            quick_status = (req_width != {1'b0, layer_width}) ? ST_WIDTH : ST_IGNORED;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (quick)
                        state_next = S_DONE;
                    else if (req_func)
                        state_next = S_SCAN_ALLOC;
                    else
                        state_next = S_SCAN_FREE;
                end
            end
            S_SCAN_FREE:  if (scan_last) state_next = S_COMMIT;
            S_SCAN_ALLOC: if (scan_last) state_next = S_SCAN_NBR;
            S_SCAN_NBR:   if (scan_last) state_next = S_COMMIT;
            S_COMMIT:     state_next = S_DONE;
            S_DONE:       if (res_ready) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // commit decision
    always_comb
    begin
        c_status   = ST_OK;
        c_start    = '0;
        c_grew     = 1'b0;
        c_total    = total_reg;
        c_fwe      = 1'b0;
        c_faddr    = '0;
        c_fdata    = '0;
        c_awe      = 1'b0;
        c_fset     = 1'b0;
        c_fclr     = 1'b0;
        c_fset_idx = '0;
        c_fclr_idx = '0;
        c_aclr     = 1'b0;
        grown      = CAP_W'(total_reg) * CAP_W'(GROWTH_FACTOR);
        region     = grown - CAP_W'(total_reg);
        if (!func_reg)
        begin
            if (best_found_reg)
            begin
                if (!aslot_found_reg)
                    c_status = ST_FULL;
                else
                begin
                    c_start = FST_W'(best_start_reg);
                    c_awe   = 1'b1;
                    if (best_len_reg == count_reg)
                    begin
                        c_fclr     = 1'b1;
                        c_fclr_idx = best_idx_reg;
                    end
                    else
                    begin
                        c_fwe   = 1'b1;
                        c_faddr = best_idx_reg;
                        c_fdata = {best_start_reg + count_reg, best_len_reg - count_reg};
                    end
                end
            end
            else if (grown > CAP_W'(MAX_LAYERS) || region < CAP_W'(count_reg))
                c_status = ST_SPACE;
            else if (!aslot_found_reg)
                c_status = ST_FULL;
            else if (region > CAP_W'(count_reg) && !fslot_found_reg)
                c_status = ST_FULL;
            else
            begin
                c_total = LEN_W'(grown);
                c_grew  = 1'b1;
                c_start = FST_W'(total_reg);
                c_awe   = 1'b1;
                if (region > CAP_W'(count_reg))
                begin
                    c_fwe      = 1'b1;
                    c_faddr    = fslot_reg;
                    c_fdata    = {total_reg + count_reg, LEN_W'(region) - count_reg};
                    c_fset     = 1'b1;
                    c_fset_idx = fslot_reg;
                end
            end
        end
        else if (!match_found_reg)
            c_status = ST_NOTALLOC;
        else if (left_found_reg)
        begin
            c_start = where_reg;
            c_aclr  = 1'b1;
            c_fwe   = 1'b1;
            c_faddr = left_idx_reg;
            c_fdata = {left_start_reg,
                       left_len_reg + m_len_reg + (right_found_reg ? right_len_reg : '0)};
            c_fclr     = right_found_reg;
            c_fclr_idx = right_idx_reg;
        end
        else if (right_found_reg)
        begin
            c_start = where_reg;
            c_aclr  = 1'b1;
            c_fwe   = 1'b1;
            c_faddr = right_idx_reg;
            c_fdata = {m_start_reg, m_len_reg + right_len_reg};
        end
        else if (!fslot_found_reg)
            c_status = ST_FULL;
        else
        begin
            c_start    = where_reg;
            c_aclr     = 1'b1;
            c_fwe      = 1'b1;
            c_faddr    = fslot_reg;
            c_fdata    = {m_start_reg, m_len_reg};
            c_fset     = 1'b1;
            c_fset_idx = fslot_reg;
        end
    end

    // memory ports
    always_comb
    begin
        free_req.raddr  = cnt_reg[TBL_AW-1:0];
        alloc_req.raddr = cnt_reg[TBL_AW-1:0];
        free_req.we     = 1'b0;
        free_req.waddr  = '0;
        free_req.wdata  = '0;
        alloc_req.we    = 1'b0;
        alloc_req.waddr = aslot_reg;
        alloc_req.wdata = {c_start == '0 ? LEN_W'(0) : LEN_W'(c_start), count_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (init_pend_reg)
                begin
                    free_req.we    = 1'b1;
                    free_req.wdata = {LEN_W'(0), total_reg};
                end
            end
            S_COMMIT:
            begin
                free_req.we    = c_fwe;
                free_req.waddr = c_faddr;
                free_req.wdata = c_fdata;
                alloc_req.we   = c_awe;
            end
            default:
            begin
                free_req.we = 1'b0;
            end
        endcase
    end

    assign res_valid        = (state_reg == S_DONE);
    assign res.status       = res_status_reg;
    assign res.start_layer  = res_start_reg;
    assign res.grew         = res_grew_reg;
    assign res.capacity     = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            init_pend_reg   <= 1'b1;
            total_reg       <= RESET_LAYERS;
            free_valid_reg  <= TBL_N'(1);
            alloc_valid_reg <= '0;
            best_found_reg  <= 1'b0;
            aslot_found_reg <= 1'b0;
            fslot_found_reg <= 1'b0;
            match_found_reg <= 1'b0;
            left_found_reg  <= 1'b0;
            right_found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (init_we)
            begin
                init_pend_reg   <= 1'b1;
                total_reg       <= init_cap;
                free_valid_reg  <= TBL_N'(1);
                alloc_valid_reg <= '0;
            end
            else if (state_reg == S_IDLE && init_pend_reg)
                init_pend_reg <= 1'b0;

            if (accept)
            begin
                cnt_reg         <= '0;
                best_found_reg  <= 1'b0;
                aslot_found_reg <= 1'b0;
                fslot_found_reg <= 1'b0;
                match_found_reg <= 1'b0;
                left_found_reg  <= 1'b0;
                right_found_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN_FREE || state_reg == S_SCAN_ALLOC
                     || state_reg == S_SCAN_NBR)
                cnt_reg <= scan_last ? '0 : cnt_reg + CNT_W'(1);

            if (state_reg == S_SCAN_FREE && scan_data)
            begin
                if (f_vld && f_len >= count_reg && (!best_found_reg || f_start < best_start_reg))
                begin
                    best_found_reg <= 1'b1;
                    best_idx_reg   <= p_idx;
                    best_start_reg <= f_start;
                    best_len_reg   <= f_len;
                end
                if (!f_vld && !fslot_found_reg)
                begin
                    fslot_found_reg <= 1'b1;
                    fslot_reg       <= p_idx;
                end
                if (!alloc_valid_reg[p_idx] && !aslot_found_reg)
                begin
                    aslot_found_reg <= 1'b1;
                    aslot_reg       <= p_idx;
                end
            end

            if (state_reg == S_SCAN_ALLOC && scan_data && !match_found_reg
                && alloc_valid_reg[p_idx] && a_start == {1'b0, where_reg})
            begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= p_idx;
                m_start_reg     <= a_start;
                m_len_reg       <= a_len;
            end

            if (state_reg == S_SCAN_NBR && scan_data)
            begin
                if (f_vld && ({1'b0, f_start} + {1'b0, f_len}) == {1'b0, m_start_reg})
                begin
                    left_found_reg <= 1'b1;
                    left_idx_reg   <= p_idx;
                    left_start_reg <= f_start;
                    left_len_reg   <= f_len;
                end
                if (f_vld && {1'b0, f_start} == ({1'b0, m_start_reg} + {1'b0, m_len_reg}))
                begin
                    right_found_reg <= 1'b1;
                    right_idx_reg   <= p_idx;
                    right_len_reg   <= f_len;
                end
                if (!f_vld && !fslot_found_reg)
                begin
                    fslot_found_reg <= 1'b1;
                    fslot_reg       <= p_idx;
                end
            end

            if (state_reg == S_COMMIT)
            begin
                total_reg <= c_total;
                if (c_fset)
                    free_valid_reg[c_fset_idx] <= 1'b1;
                if (c_fclr)
                    free_valid_reg[c_fclr_idx] <= 1'b0;
                if (c_awe)
                    alloc_valid_reg[aslot_reg] <= 1'b1;
                if (c_aclr)
                    alloc_valid_reg[match_idx_reg] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg       <= req_func;
            count_reg      <= req_count;
            where_reg      <= req_where;
            res_status_reg <= quick_status;
            res_start_reg  <= '0;
            res_grew_reg   <= 1'b0;
        end
        else if (state_reg == S_COMMIT)
        begin
            res_status_reg <= c_status;
            res_start_reg  <= c_start;
            res_grew_reg   <= c_grew;
        end
    end

endmodule

/* hdl/first_fit_range_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_range_allocator_top
// First-fit allocator of contiguous layer ranges with coalescing on free.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  s_*      | in        | s_tvalid/s_tready  | request (tdata, tuser = func)
//  m_*      | out       | m_tvalid/m_tready  | result (tdata, tuser = status)
//  cfg_*    | in        | cfg_valid/cfg_ready| register index and value
//
//  A rejected request (width mismatch, zero count, nonzero origin) skips
//  the scans and goes straight to its result. An allocate makes one pass
//  over the free-range memory, through its single read port, then commits.
//  A free makes a pass over the allocation memory, then a pass over the
//  free-range memory for neighbors. After reset, and after every write of
//  initial_layers, the single free range is written before s_tready rises.
//  The result register frees the engine: a stalled m_tready holds only the
//  next result, never an accepted request already in flight.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_top
    import ffra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] req_width, [28:16] layer_count, [44:29] origin_x,
    // [60:45] origin_y, [72:61] free_start, rest zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] func
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [11:0] start_layer, [12] grew, [25:13] capacity, rest zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // [2:0] status
    output logic [STAT_W-1:0]     m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WID_W-1:0]      cfg_data
);

    logic [WID_W-1:0]  layer_width_reg;
    logic              init_we;
    logic [LEN_W-1:0]  init_cap;
    logic              cfg_xfer;

    ffra_mem_req_t     free_req, alloc_req;
    logic [ENT_W-1:0]  free_rdata, alloc_rdata;

    logic              res_valid, res_ready;
    ffra_result_t      res;

    logic              m_tvalid_reg;
    ffra_result_t      out_reg;

    // configuration is always taken
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign init_we   = cfg_xfer && (cfg_index == REG_INITIAL_LAYERS);

    // clamp the capacity to 1..MAX_LAYERS
    always_comb
    begin
        if (cfg_data[LEN_W-1:0] == '0)
            init_cap = LEN_W'(1);
        else if (cfg_data[LEN_W-1:0] > LEN_W'(MAX_LAYERS))
            init_cap = LEN_W'(MAX_LAYERS);
        else
            init_cap = cfg_data[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            layer_width_reg <= RESET_WIDTH;
        else if (cfg_xfer && cfg_index == REG_LAYER_WIDTH)
            layer_width_reg <= cfg_data;
    end

    ffra_ram #(.WIDTH(ENT_W), .DEPTH(TBL_N)) u_free_mem (
        .clk   (clk),
        .we    (free_req.we),
        .waddr (free_req.waddr),
        .wdata (free_req.wdata),
        .raddr (free_req.raddr),
        .rdata (free_rdata)
    );

    ffra_ram #(.WIDTH(ENT_W), .DEPTH(TBL_N)) u_alloc_mem (
        .clk   (clk),
        .we    (alloc_req.we),
        .waddr (alloc_req.waddr),
        .wdata (alloc_req.wdata),
        .raddr (alloc_req.raddr),
        .rdata (alloc_rdata)
    );

    ffra_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_func    (s_tuser),
        .req_width   (s_tdata[15:0]),
        .req_count   (s_tdata[28:16]),
        .req_ox      (s_tdata[44:29]),
        .req_oy      (s_tdata[60:45]),
        .req_where   (s_tdata[72:61]),
        .layer_width (layer_width_reg),
        .init_we     (init_we),
        .init_cap    (init_cap),
        .free_req    (free_req),
        .free_rdata  (free_rdata),
        .alloc_req   (alloc_req),
        .alloc_rdata (alloc_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output register: load whenever it is empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_ready)
            m_tvalid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {6'd0, out_reg.capacity, out_reg.grew, out_reg.start_layer};

endmodule

/* hdl/ffra_checker.sv */
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks of the range allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffra_checker
    import ffra_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]     m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a failed request grants no layers
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[12:0] == '0)
        else $error("failed request carries a start or growth");

    // capacity is never zero
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[25:13] != '0)
        else $error("zero capacity reported");

    // status stays within its codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= ST_FULL)
        else $error("unknown status");

endmodule

bind first_fit_range_allocator_top ffra_checker u_ffra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit range allocator: a behavioral
// allocator model predicts every result; a queue-fed driver and a monitor
// exercise allocate/free traffic with random idling on both streams.
// ----------------------------------------------------------------------------
module tb
    import ffra_pkg::*;
();

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FST_W-1:0]  start_layer;
        logic              grew;
        logic [LEN_W-1:0]  capacity;
    } outcome_t;

    typedef struct packed {
        logic                 func;
        logic [IN_DATA_W-1:0] data;
    } request_t;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [WID_W-1:0]      cfg_data = '0;

    first_fit_range_allocator_top dut (.*);

    always #10 clk = ~clk;

    // allocator model state
    int unsigned mdl_width;
    int unsigned mdl_init;
    int unsigned fr_start [TBL_N];
    int unsigned fr_len   [TBL_N];
    bit          fr_ok    [TBL_N];
    int unsigned al_start [TBL_N];
    int unsigned al_len   [TBL_N];
    bit          al_ok    [TBL_N];
    int unsigned cap_now;

    request_t    pending_reqs[$];
    outcome_t    expected_results[$];
    int unsigned live_starts[$];   // starts the model holds as allocated
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_sender = 1'b0;

    function automatic void rebuild_tables();
        int unsigned c;
        c = mdl_init;
        if (c < 1) c = 1;
        if (c > MAX_LAYERS) c = MAX_LAYERS;
        for (int i = 0; i < TBL_N; i++)
        begin
            fr_start[i] = 0; fr_len[i] = 0; fr_ok[i] = 0; al_ok[i] = 0;
        end
        fr_len[0] = c;
        fr_ok[0] = 1;
        cap_now = c;
        live_starts.delete();
    endfunction

    function automatic int first_hole(input bit v [TBL_N]);
        for (int i = 0; i < TBL_N; i++)
            if (!v[i]) return i;
        return -1;
    endfunction

    function automatic logic [STAT_W-1:0] grant_layers(input int unsigned cnt,
            output int unsigned st, output bit gr);
        int best, aslot, fslot;
        int unsigned old_cap, new_cap, region;
        best = -1;
        aslot = first_hole(al_ok);
        fslot = first_hole(fr_ok);
        st = 0;
        gr = 0;
        if (cnt == 0) return ST_IGNORED;
        for (int i = 0; i < TBL_N; i++)
            if (fr_ok[i] && fr_len[i] >= cnt && (best < 0 || fr_start[i] < fr_start[best]))
                best = i;
        if (best >= 0)
        begin
            if (aslot < 0) return ST_FULL;
            st = fr_start[best];
            al_start[aslot] = st; al_len[aslot] = cnt; al_ok[aslot] = 1;
            if (fr_len[best] == cnt)
            begin
                fr_ok[best] = 0; fr_start[best] = 0; fr_len[best] = 0;
            end
            else
            begin
                fr_start[best] += cnt; fr_len[best] -= cnt;
            end
            return ST_OK;
        end
        old_cap = cap_now;
        new_cap = old_cap * GROWTH_FACTOR;
        if (new_cap > MAX_LAYERS) return ST_SPACE;
        region = new_cap - old_cap;
        if (region < cnt) return ST_SPACE;
        if (aslot < 0) return ST_FULL;
        if (region > cnt && fslot < 0) return ST_FULL;
        cap_now = new_cap;
        gr = 1;
        st = old_cap;
        al_start[aslot] = old_cap; al_len[aslot] = cnt; al_ok[aslot] = 1;
        if (region > cnt)
        begin
            fr_start[fslot] = old_cap + cnt; fr_len[fslot] = region - cnt;
            fr_ok[fslot] = 1;
        end
        return ST_OK;
    endfunction

    function automatic logic [STAT_W-1:0] release_range(input int unsigned where);
        int a, lft, rgt, f;
        int unsigned s, n;
        a = -1; lft = -1; rgt = -1;
        for (int i = 0; i < TBL_N; i++)
            if (al_ok[i] && al_start[i] == where)
            begin
                a = i;
                break;
            end
        if (a < 0) return ST_NOTALLOC;
        s = al_start[a];
        n = al_len[a];
        for (int i = 0; i < TBL_N; i++)
        begin
            if (!fr_ok[i]) continue;
            if (fr_start[i] + fr_len[i] == s) lft = i;
            if (fr_start[i] == s + n) rgt = i;
        end
        if (lft >= 0)
        begin
            fr_len[lft] += n;
            if (rgt >= 0)
            begin
                fr_len[lft] += fr_len[rgt];
                fr_ok[rgt] = 0; fr_start[rgt] = 0; fr_len[rgt] = 0;
            end
        end
        else if (rgt >= 0)
        begin
            fr_start[rgt] = s; fr_len[rgt] += n;
        end
        else
        begin
            f = first_hole(fr_ok);
            if (f < 0) return ST_FULL;
            fr_start[f] = s; fr_len[f] = n; fr_ok[f] = 1;
        end
        al_ok[a] = 0;
        return ST_OK;
    endfunction

    // compute the outcome of one accepted request and queue it
    function automatic void predict_outcome(input request_t r);
        outcome_t    o;
        int unsigned st;
        bit          gr;
        logic [15:0] rw, ox, oy;
        logic [12:0] cnt;
        logic [11:0] fs;
        rw  = r.data[15:0];
        cnt = r.data[28:16];
        ox  = r.data[44:29];
        oy  = r.data[60:45];
        fs  = r.data[72:61];
        st = 0;
        gr = 0;
        if (r.func == FN_ALLOC)
        begin
            if (rw != mdl_width) o.status = ST_WIDTH;
            else o.status = grant_layers(cnt, st, gr);
            if (o.status == ST_OK) live_starts.push_back(st);
        end
        else if (ox != 0 || oy != 0)
            o.status = ST_IGNORED;
        else
        begin
            o.status = release_range(fs);
            if (o.status == ST_OK)
            begin
                st = fs;
                foreach (live_starts[k])
                    if (live_starts[k] == fs)
                    begin
                        live_starts.delete(k);
                        break;
                    end
            end
        end
        if (o.status != ST_OK) st = 0;
        o.start_layer = st[11:0];
        o.grew = gr;
        o.capacity = cap_now[12:0];
        expected_results.push_back(o);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic request_t make_alloc(input int unsigned w, input int unsigned n);
        request_t r;
        r.func = FN_ALLOC;
        r.data = '0;
        r.data[15:0] = w[15:0];
        r.data[28:16] = n[12:0];
        // origin and free_start are don't-care for allocate; randomize them
        r.data[44:29] = 16'($urandom);
        r.data[60:45] = 16'($urandom);
        r.data[72:61] = 12'($urandom);
        return r;
    endfunction

    function automatic request_t make_free(input int unsigned at, input bit noisy);
        request_t r;
        r.func = FN_FREE;
        r.data = '0;
        r.data[15:0] = 16'($urandom);
        r.data[28:16] = 13'($urandom);
        r.data[72:61] = at[11:0];
        if (noisy)
        begin
            r.data[44:29] = 16'($urandom);
            r.data[60:45] = 16'($urandom);
            if (r.data[60:29] == 0) r.data[29] = 1'b1;
        end
        return r;
    endfunction

    // driver: advance through the pending queue, idling at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_outcome('{s_tuser, s_tdata});
                void'(pending_reqs.pop_front());
            end
            if ((s_tvalid && !s_tready) || (pending_reqs.size() > 0
                    && (!hold_sender || expected_results.size() == 0)
                    && $urandom_range(99) >= send_idle_pct))
            begin
                if (!(s_tvalid && !s_tready))
                begin
                    s_tvalid <= 1'b1;
                    {s_tuser, s_tdata} <= pending_reqs[0];
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, status", m_tuser, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[11:0] != want.start_layer)
                        report_mismatch("start_layer", m_tdata[11:0], want.start_layer);
                    if (m_tdata[12] != want.grew)
                        report_mismatch("grew", m_tdata[12], want.grew);
                    if (m_tdata[25:13] != want.capacity)
                        report_mismatch("capacity", m_tdata[25:13], want.capacity);
                    if (m_tdata[31:26] != 0)
                        report_mismatch("pad bits", m_tdata[31:26], 0);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= WID_W'(val);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_LAYER_WIDTH) mdl_width = val & 32'h7FFF;
        else
        begin
            mdl_init = val & 32'h1FFF;
            rebuild_tables();
        end
    endtask

    // wait for all queued work to drain, then let the engine settle
    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    // mostly well-formed traffic: allocations and frees of live ranges
    task automatic random_traffic(input int n);
        int unsigned pick, k;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                pending_reqs.push_back(make_alloc(mdl_width,
                    ($urandom_range(9) == 0) ? $urandom_range(4096, 0) : $urandom_range(24, 1)));
            else if (pick < 80 && live_starts.size() > 0)
            begin
                // live list is only approximate ahead of acceptance; fine
                k = $urandom_range(live_starts.size() - 1);
                pending_reqs.push_back(make_free(live_starts[k], 1'b0));
            end
            else if (pick < 88)
                pending_reqs.push_back(make_free($urandom_range(4095), 1'b0));
            else if (pick < 93)
                pending_reqs.push_back(make_free($urandom_range(4095), 1'b1));
            else
                pending_reqs.push_back(make_alloc($urandom & 16'hFFFF, $urandom_range(8)));
            // keep the lookahead short so frees target live ranges
            wait (pending_reqs.size() < 2);
        end
    endtask

    initial
    begin
        mdl_width = RESET_WIDTH;
        mdl_init = RESET_LAYERS;
        rebuild_tables();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 20;
        recv_idle_pct = 88;

        // directed: extremes at reset configuration
        pending_reqs.push_back(make_alloc(mdl_width, 0));
        pending_reqs.push_back(make_alloc(mdl_width + 1, 4));
        pending_reqs.push_back(make_alloc(16'hFFFF, 4));
        pending_reqs.push_back(make_alloc(mdl_width, 4));
        pending_reqs.push_back(make_alloc(mdl_width, 12));
        pending_reqs.push_back(make_alloc(mdl_width, 30));
        pending_reqs.push_back(make_alloc(mdl_width, 48));
        pending_reqs.push_back(make_alloc(mdl_width, 4096));
        pending_reqs.push_back(make_free(4, 1'b0));
        pending_reqs.push_back(make_free(0, 1'b0));
        pending_reqs.push_back(make_free(0, 1'b0));
        pending_reqs.push_back(make_free(16, 1'b1));
        pending_reqs.push_back(make_free(4095, 1'b0));
        pending_reqs.push_back(make_free(16, 1'b0));
        pending_reqs.push_back(make_free(46, 1'b0));
        pending_reqs.push_back(make_alloc(mdl_width, 8191));
        drain();

        // hold each transfer until every outstanding result is back
        hold_sender = 1'b1;
        for (int i = 0; i < 8; i++)
            pending_reqs.push_back(make_alloc(mdl_width, 3));
        drain();
        hold_sender = 1'b0;

        // table exhaustion: many single-layer grants then scattered frees
        write_reg(REG_LAYER_WIDTH, 16384);
        write_reg(REG_INITIAL_LAYERS, 4096);
        for (int i = 0; i < 70; i++)
            pending_reqs.push_back(make_alloc(16384, 1));
        for (int i = 0; i < 66; i += 2)
            pending_reqs.push_back(make_free(i, 1'b0));
        drain();

        write_reg(REG_LAYER_WIDTH, 1);
        write_reg(REG_INITIAL_LAYERS, 1);
        random_traffic(200);
        drain();

        send_idle_pct = 88;
        recv_idle_pct = 20;
        write_reg(REG_LAYER_WIDTH, 32767);
        write_reg(REG_INITIAL_LAYERS, 0);
        random_traffic(150);
        drain();

        write_reg(REG_INITIAL_LAYERS, 8191);
        random_traffic(100);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_LAYER_WIDTH, $urandom_range(16384, 1));
        write_reg(REG_INITIAL_LAYERS, $urandom_range(64, 2));
        random_traffic(250);
        drain();

        if (errors == 0)
            $display("first_fit_range_allocator_top regression: pass");
        else
            $display("first_fit_range_allocator_top regression: fail");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("first_fit_range_allocator_top regression: fail");
        $finish;
    end
endmodule

/* filelist.f */
hdl/ffra_pkg.sv
hdl/ffra_ram.sv
hdl/ffra_engine.sv
hdl/first_fit_range_allocator_top.sv
hdl/ffra_checker.sv
test/tb.sv
